FILE: rtl/spgp_pkg.sv
// Shared types, register codes and constant tables for the sky polar grid projection.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package spgp_pkg;

   localparam int SINE_TABLE_POINTS = 91;
   localparam int ROM_INDEX_WIDTH   = $clog2(SINE_TABLE_POINTS);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_ROWS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_COLS   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CELL_HEIGHT = 3'd3;

   localparam logic [7:0] RESET_GRID_ROWS   = 8'd24;
   localparam logic [7:0] RESET_GRID_COLS   = 8'd48;
   localparam logic [7:0] RESET_CELL_WIDTH  = 8'd8;
   localparam logic [7:0] RESET_CELL_HEIGHT = 8'd16;
   localparam logic [7:0] MIN_GRID_SIZE     = 8'd3;

   // azimuth reduction: (az + 32768) mod 360 by reciprocal multiply
   localparam int          AZ_RECIP_SHIFT = 24;
   localparam logic [31:0] AZ_RECIP       = 32'((1 << AZ_RECIP_SHIFT) / 360 + 1);
   localparam logic [16:0] AZ_MODULUS     = 17'd360;
   localparam logic [8:0]  AZ_BIAS_REM    = 9'(32768 % 360);
   localparam logic [8:0]  AZ_BIAS_FIX    = 9'(360 - 32768 % 360);

   localparam logic [8:0] DEG_90  = 9'd90;
   localparam logic [8:0] DEG_180 = 9'd180;
   localparam logic [8:0] DEG_270 = 9'd270;
   localparam logic [8:0] DEG_360 = 9'd360;
   localparam logic [6:0] MAX_ELEVATION = 7'd90;

   localparam logic [31:0] ROUND_Q15 = 32'd16384;
   localparam logic [22:0] ROUND_DY  = 23'd16384;
   localparam logic [30:0] ROUND_DX  = 31'd4194304;

   // column radius divider: quotient bits of (half_rows*cell_height) << 8
   localparam int          DIV_NUM_WIDTH   = 23;
   localparam int          DIV_COUNT_WIDTH = $clog2(DIV_NUM_WIDTH + 1);
   localparam logic [DIV_COUNT_WIDTH-1:0] DIV_STEPS = DIV_COUNT_WIDTH'(DIV_NUM_WIDTH);

   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [15:0] azimuth;
      logic signed [7:0]  elevation;
   } req_data_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] row;
      logic [7:0] col;
      logic       located;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0]  grid_rows;
      logic [7:0]  grid_cols;
      logic [6:0]  half_rows;
      logic [6:0]  half_cols;
      logic [14:0] col_radius;
      logic        valid;
      logic        ready;
   } cfg_type;

   typedef struct packed {
      logic                       el_ok;
      logic                       located;
      logic                       sin_neg;
      logic                       cos_neg;
      logic [ROM_INDEX_WIDTH-1:0] sin_idx;
      logic [ROM_INDEX_WIDTH-1:0] cos_idx;
      logic [ROM_INDEX_WIDTH-1:0] scale_idx;
   } item_type;

   typedef logic [15:0] rom_type [SINE_TABLE_POINTS];

   localparam rom_type SINE_ROM = '{
          16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,
       16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
       16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
       16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668,
      16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
      16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
      16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
      16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
      16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
      16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
      16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
      16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
      16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
      16'd32643, 16'd32688, 16'd32723, 16'd32751, 16'd32763,
      16'd32768
   };

   function automatic rom_type build_scale_rom();
      rom_type t;
      for (int i = 0; i < SINE_TABLE_POINTS; i++) begin
         t[i] = 16'((i * 65536 + 90) / 180);
      end
      return t;
   endfunction

   // radius scale for (90 - elevation), Q1.15
   localparam rom_type SCALE_ROM = build_scale_rom();

endpackage

`default_nettype wire

FILE: rtl/spgp_csr.sv
// Configuration registers and the bit-serial divider for the column radius.
// Depends on spgp_pkg.
`default_nettype none

module spgp_csr (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_we,
   input  wire  [spgp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [spgp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output spgp_pkg::cfg_type                      cfg
);

   logic [7:0] rows_ff, cols_ff, cw_ff, ch_ff;
   logic       pend_ff, busy_ff;
   logic [spgp_pkg::DIV_COUNT_WIDTH-1:0] cnt_ff;
   logic [spgp_pkg::DIV_NUM_WIDTH-1:0]   num_ff;
   logic [7:0]  rem_ff;
   logic [14:0] rc_ff;

   logic [6:0]  half_rows, half_cols;
   logic [14:0] span_rows, span_cols;
   logic        capped;
   logic [8:0]  rem_shift;
   logic        fits;
   logic [7:0]  rem_in;

   assign half_rows = rows_ff[7:1];
   assign half_cols = cols_ff[7:1];
   assign span_rows = 15'(half_rows) * 15'(ch_ff);
   assign span_cols = 15'(half_cols) * 15'(cw_ff);
   assign capped    = span_rows > span_cols;

   assign rem_shift = {rem_ff, num_ff[spgp_pkg::DIV_NUM_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, cw_ff};
   assign rem_in    = fits ? 8'(rem_shift - {1'b0, cw_ff}) : rem_shift[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= spgp_pkg::RESET_GRID_ROWS;
         cols_ff <= spgp_pkg::RESET_GRID_COLS;
         cw_ff   <= spgp_pkg::RESET_CELL_WIDTH;
         ch_ff   <= spgp_pkg::RESET_CELL_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            spgp_pkg::CSR_GRID_ROWS:   rows_ff <= csr_wdata;
            spgp_pkg::CSR_GRID_COLS:   cols_ff <= csr_wdata;
            spgp_pkg::CSR_CELL_WIDTH:  cw_ff   <= csr_wdata;
            spgp_pkg::CSR_CELL_HEIGHT: ch_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // restart the division on every write
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b1;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (csr_we) begin
         pend_ff <= 1'b1;
         busy_ff <= 1'b0;
      end else if (pend_ff) begin
         pend_ff <= 1'b0;
         busy_ff <= 1'b1;
         cnt_ff  <= spgp_pkg::DIV_STEPS;
         num_ff  <= {span_rows, 8'b0};
         rem_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            rem_ff <= rem_in;
            num_ff <= {num_ff[spgp_pkg::DIV_NUM_WIDTH-2:0], fits};
         end else begin
            busy_ff <= 1'b0;
            rc_ff   <= capped ? {half_cols, 8'b0} : num_ff[14:0];
         end
      end
   end

   always_comb begin
      cfg.grid_rows  = rows_ff;
      cfg.grid_cols  = cols_ff;
      cfg.half_rows  = half_rows;
      cfg.half_cols  = half_cols;
      cfg.col_radius = rc_ff;
      cfg.valid      = (rows_ff >= spgp_pkg::MIN_GRID_SIZE) &&
                       (cols_ff >= spgp_pkg::MIN_GRID_SIZE) &&
                       (cw_ff != 8'd0) && (ch_ff != 8'd0);
      cfg.ready      = !pend_ff && !busy_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/spgp_front.sv
// Front end: accepts a word, reduces azimuth to a quadrant and table indices.
// Depends on spgp_pkg; feeds spgp_fifo.
`default_nettype none

module spgp_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  spgp_pkg::req_data_type req_data,
   input  wire                          cfg_ready,
   input  wire                          fifo_full,
   output logic                         push,
   output spgp_pkg::item_type           push_item
);

   logic                valid_ff;
   logic                valid_in;
   logic [31:0]         prod_ff;
   logic [15:0]         u_ff;
   logic signed [7:0]   el_ff;
   logic                located_ff;

   logic        accept;
   logic [15:0] u_in;
   logic [7:0]  quot;
   logic [16:0] quot_mul;
   logic [8:0]  rem, ang;
   logic        el_ok;
   logic [8:0]  s_idx, c_idx;
   logic        s_neg, c_neg;

   assign req_stall = !cfg_ready || (valid_ff && fifo_full);
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !fifo_full;
   assign u_in      = {~req_data.azimuth[15], req_data.azimuth[14:0]};
   assign valid_in  = accept ? 1'b1 : (push ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff    <= 32'(u_in) * spgp_pkg::AZ_RECIP;
         u_ff       <= u_in;
         el_ff      <= req_data.elevation;
         located_ff <= (req_data.azimuth != 16'sd0) || (req_data.elevation != 8'sd0);
      end
   end

   always_comb begin
      quot     = 8'(prod_ff >> spgp_pkg::AZ_RECIP_SHIFT);
      quot_mul = 17'(quot) * spgp_pkg::AZ_MODULUS;
      rem      = 9'(17'(u_ff) - quot_mul);
      ang      = (rem >= spgp_pkg::AZ_BIAS_REM) ? rem - spgp_pkg::AZ_BIAS_REM
                                                 : rem + spgp_pkg::AZ_BIAS_FIX;
      if (ang <= spgp_pkg::DEG_90) begin
         s_idx = ang;
         c_idx = spgp_pkg::DEG_90 - ang;
         s_neg = 1'b0;
         c_neg = 1'b0;
      end else if (ang <= spgp_pkg::DEG_180) begin
         s_idx = spgp_pkg::DEG_180 - ang;
         c_idx = ang - spgp_pkg::DEG_90;
         s_neg = 1'b0;
         c_neg = 1'b1;
      end else if (ang <= spgp_pkg::DEG_270) begin
         s_idx = ang - spgp_pkg::DEG_180;
         c_idx = spgp_pkg::DEG_270 - ang;
         s_neg = 1'b1;
         c_neg = 1'b1;
      end else begin
         s_idx = spgp_pkg::DEG_360 - ang;
         c_idx = ang - spgp_pkg::DEG_270;
         s_neg = 1'b1;
         c_neg = 1'b0;
      end
      el_ok = !el_ff[7] && (el_ff[6:0] <= spgp_pkg::MAX_ELEVATION);

      push_item.el_ok     = el_ok;
      push_item.located   = located_ff;
      push_item.sin_neg   = s_neg;
      push_item.cos_neg   = c_neg;
      push_item.sin_idx   = spgp_pkg::ROM_INDEX_WIDTH'(s_idx);
      push_item.cos_idx   = spgp_pkg::ROM_INDEX_WIDTH'(c_idx);
      push_item.scale_idx = el_ok ? spgp_pkg::ROM_INDEX_WIDTH'(spgp_pkg::MAX_ELEVATION - el_ff[6:0])
                                  : '0;
   end

endmodule

`default_nettype wire

FILE: rtl/spgp_fifo.sv
// Short queue of classified words between the front and back ends.
// Depends on spgp_pkg.
`default_nettype none

module spgp_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire  spgp_pkg::item_type push_item,
   output logic                     full,
   input  wire                      pop,
   output spgp_pkg::item_type       pop_item,
   output logic                     empty
);

   spgp_pkg::item_type                   mem_ff [spgp_pkg::FIFO_DEPTH];
   logic [spgp_pkg::FIFO_PTR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [spgp_pkg::FIFO_CNT_WIDTH-1:0]  count_ff;
   logic                                 do_push, do_pop;

   assign full     = count_ff == spgp_pkg::FIFO_CNT_WIDTH'(spgp_pkg::FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/spgp_back.sv
// Back end: six-stage pipeline from table indices to a clamped grid position.
// Depends on spgp_pkg; drains spgp_fifo and drives the result port.
`default_nettype none

module spgp_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  spgp_pkg::cfg_type      cfg,
   input  wire  spgp_pkg::item_type     pop_item,
   input  wire                          empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output spgp_pkg::rsp_data_type       rsp_data
);

   typedef struct packed {
      logic ok;
      logic located;
      logic sin_neg;
      logic cos_neg;
   } tag_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic go1, go2, go3, go4, go5, go6;

   tag_type     t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic [15:0] smag1_ff, cmag1_ff, kq1_ff;
   logic [31:0] ps2_ff, pc2_ff;
   logic [15:0] ms3_ff, mc3_ff;
   logic [22:0] pdy4_ff;
   logic [30:0] pdx4_ff;
   logic [7:0]  dy5_ff, dx5_ff;
   spgp_pkg::rsp_data_type out_ff;

   logic signed [9:0] row_s, col_s;
   logic [7:0]        row_c, col_c;
   spgp_pkg::rsp_data_type out_in;

   assign go6 = !v6_ff || !rsp_stall;
   assign go5 = !v5_ff || go6;
   assign go4 = !v4_ff || go5;
   assign go3 = !v3_ff || go4;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign pop = go1 && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= !empty;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
         if (go5) v5_ff <= v4_ff;
         if (go6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         t1_ff    <= '{ok: pop_item.el_ok && cfg.valid, located: pop_item.located,
                       sin_neg: pop_item.sin_neg, cos_neg: pop_item.cos_neg};
         smag1_ff <= spgp_pkg::SINE_ROM[pop_item.sin_idx];
         cmag1_ff <= spgp_pkg::SINE_ROM[pop_item.cos_idx];
         kq1_ff   <= spgp_pkg::SCALE_ROM[pop_item.scale_idx];
      end
      if (go2) begin
         t2_ff  <= t1_ff;
         ps2_ff <= 32'(smag1_ff) * 32'(kq1_ff);
         pc2_ff <= 32'(cmag1_ff) * 32'(kq1_ff);
      end
      if (go3) begin
         t3_ff  <= t2_ff;
         ms3_ff <= 16'((ps2_ff + spgp_pkg::ROUND_Q15) >> 15);
         mc3_ff <= 16'((pc2_ff + spgp_pkg::ROUND_Q15) >> 15);
      end
      if (go4) begin
         t4_ff   <= t3_ff;
         pdy4_ff <= 23'(32'(mc3_ff) * 32'(cfg.half_rows));
         pdx4_ff <= 31'(32'(ms3_ff) * 32'(cfg.col_radius));
      end
      if (go5) begin
         t5_ff  <= t4_ff;
         dy5_ff <= 8'((pdy4_ff + spgp_pkg::ROUND_DY) >> 15);
         dx5_ff <= 8'((pdx4_ff + spgp_pkg::ROUND_DX) >> 23);
      end
      if (go6) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      row_s = t5_ff.cos_neg ? $signed({3'b0, cfg.half_rows}) + $signed({2'b0, dy5_ff})
                            : $signed({3'b0, cfg.half_rows}) - $signed({2'b0, dy5_ff});
      col_s = t5_ff.sin_neg ? $signed({3'b0, cfg.half_cols}) - $signed({2'b0, dx5_ff})
                            : $signed({3'b0, cfg.half_cols}) + $signed({2'b0, dx5_ff});
      if (row_s < 10'sd0) begin
         row_c = 8'd0;
      end else if (row_s >= $signed({2'b0, cfg.grid_rows})) begin
         row_c = cfg.grid_rows - 8'd1;
      end else begin
         row_c = row_s[7:0];
      end
      if (col_s < 10'sd0) begin
         col_c = 8'd0;
      end else if (col_s >= $signed({2'b0, cfg.grid_cols})) begin
         col_c = cfg.grid_cols - 8'd1;
      end else begin
         col_c = col_s[7:0];
      end
      out_in.ok      = t5_ff.ok;
      out_in.row     = t5_ff.ok ? row_c : 8'd0;
      out_in.col     = t5_ff.ok ? col_c : 8'd0;
      out_in.located = t5_ff.located;
   end

   assign rsp_valid = v6_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

FILE: rtl/sky_polar_grid_projection_core.sv
// Sky polar grid projection: azimuth and elevation to a row and column of a character grid.
// Top level; instantiates spgp_csr, spgp_front, spgp_fifo and spgp_back, uses spgp_pkg.
//
// One result word per request word, in order, at one word per clock when neither side stalls.
// A word is registered once in the front end (azimuth reduction), passes a four-entry queue and
// takes six back-end stages. The column radius comes from a bit-serial divider giving one
// quotient bit per cycle: after reset and after every register write, req_stall stays high
// while it recomputes. Writes to an index beyond cell_height are ignored. Registers must only
// be written with the block idle.
`default_nettype none

module sky_polar_grid_projection_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  spgp_pkg::req_data_type           req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output spgp_pkg::rsp_data_type                 rsp_data,
   input  wire                                    csr_we,
   input  wire  [spgp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [spgp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   spgp_pkg::cfg_type  cfg;
   spgp_pkg::item_type push_item, pop_item;
   logic               push, pop, fifo_full, fifo_empty;

   spgp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg_ready (cfg.ready),
      .fifo_full (fifo_full),
      .push      (push),
      .push_item (push_item)
   );

   spgp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   spgp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_item  (pop_item),
      .empty     (fifo_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/spgp_checker.sv
// Port-level checks for the sky polar grid projection, bound to the top level.
// Depends on spgp_pkg and sky_polar_grid_projection_core.
`default_nettype none

module spgp_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    req_valid,
   input wire                                    req_stall,
   input wire  spgp_pkg::req_data_type           req_data,
   input wire                                    rsp_valid,
   input wire                                    rsp_stall,
   input wire  spgp_pkg::rsp_data_type           rsp_data,
   input wire                                    csr_we,
   input wire  [spgp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input wire  [spgp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.row == 8'd0 && rsp_data.col == 8'd0)
      else $error("rejected word carries a position");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_stall: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken before column radius is ready");

   a_write_stall: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("request taken while column radius recomputes");

endmodule

bind sky_polar_grid_projection_core spgp_checker u_spgp_checker (.*);

`default_nettype wire
